// ===== hw/rtl/bra_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bra_pkg
// Shared types, codes and sizes for the bitmap run allocator.
// ---------------------------------------------------------------------------
package bra_pkg;

   localparam int MAP_BYTES = 128;
   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = $clog2(MAP_BYTES);
   localparam int CFG_W     = 8;
   localparam int IDX_W     = 10;
   localparam int RUN_W     = 11;
   localparam int LIM_W     = 11;

   localparam logic [1:0] KIND_SCAN  = 2'd0;
   localparam logic [1:0] KIND_SET   = 2'd1;
   localparam logic [1:0] KIND_TEST  = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] start;
   } scan_res_type;

endpackage
`default_nettype wire

// ===== hw/rtl/bitmap_run_allocator_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_run_allocator_top
// First-fit allocator over a bitmap of up to 1024 bits, one byte per word.
// ---------------------------------------------------------------------------
// Usage:
//   Drive req_* and raise start; the item is taken at an edge where busy is
//   low. Every item gives one result, shown for one cycle with rsp_strobe;
//   the receiver must take it then, it cannot stall the block.
//   kind scan  : walks the map one byte per cycle through the run tracker,
//                up to the last byte in use. A zero or too-long run answers
//                straight from idle, with no scan.
//   kind set   : read-modify-write of one byte.
//   kind test  : one byte read.
//   kind clear : drops every byte's valid bit.
//   Out-of-range set or test answers straight from idle with rsp_bad_index.
//   The single memory read port sets the scan rate of one byte per cycle.
//   The next item can be taken at the edge that ends the result cycle, so
//   items follow one another at the latency of each.
//   csr_* writes bytes_in_use; write it only while no item is in flight.
//   Reset frees every bit and sets bytes_in_use to 128; no clearing pass.
// ---------------------------------------------------------------------------
module bitmap_run_allocator_top
   import bra_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [1:0]       req_kind,
   input  wire logic [IDX_W-1:0] req_bit_index,
   input  wire logic             req_set_value,
   input  wire logic [RUN_W-1:0] req_run_length,
   output logic                  rsp_strobe,
   output logic                  rsp_found,
   output logic      [IDX_W-1:0] rsp_start_index,
   output logic                  rsp_bit_value,
   output logic                  rsp_bad_index,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CFG_W-1:0] csr_bytes_in_use
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RMW  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CFG_W-1:0]  bytes_ff;
   logic [1:0]        kind_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              val_ff;
   logic [RUN_W-1:0]  want_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] data_byte_ff;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]  rsp_start_ff, rsp_start_in;
   logic              rsp_bit_ff, rsp_bit_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic [CFG_W-1:0]  limit_bytes;
   logic [LIM_W-1:0]  limit_bits;
   logic              accept;
   logic              clear_all;
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] bit_mask;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic              scan_clear;
   logic              scan_step;
   logic              last_byte;
   scan_res_type      scan_res;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign accept    = start && !busy;

   assign limit_bytes = (bytes_ff > CFG_W'(MAP_BYTES)) ? CFG_W'(MAP_BYTES) : bytes_ff;
   assign limit_bits  = {limit_bytes, 3'b000};
   assign last_byte   = ({1'b0, data_byte_ff} == (limit_bytes - CFG_W'(1)));
   assign bit_mask    = BYTE_W'(1) << idx_ff[2:0];
   assign rd_addr     = (state_ff == ST_SCAN) ? addr_ff : req_bit_index[IDX_W-1:3];
   assign wr_data     = val_ff ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

   bra_map_mem u_map (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .wr_en     (wr_en),
      .wr_addr   (idx_ff[IDX_W-1:3]),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   bra_run_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .clear     (scan_clear),
      .step      (scan_step),
      .map_byte  (rd_data),
      .byte_base (data_byte_ff),
      .want      (want_ff),
      .result    (scan_res)
   );

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      pend_in       = 1'b0;
      clear_all     = 1'b0;
      wr_en         = 1'b0;
      scan_clear    = 1'b0;
      scan_step     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_bit_in    = rsp_bit_ff;
      rsp_bad_in    = rsp_bad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_SCAN: begin
                     if (req_run_length == '0 || req_run_length > limit_bits) begin
                        rsp_strobe_in = 1'b1;
                        rsp_found_in  = 1'b0;
                        rsp_start_in  = '0;
                        rsp_bit_in    = 1'b0;
                        rsp_bad_in    = 1'b0;
                     end else begin
                        state_in   = ST_SCAN;
                        addr_in    = '0;
                        scan_clear = 1'b1;
                     end
                  end
                  KIND_SET, KIND_TEST: begin
                     if ({1'b0, req_bit_index} >= limit_bits) begin
                        rsp_strobe_in = 1'b1;
                        rsp_found_in  = 1'b0;
                        rsp_start_in  = '0;
                        rsp_bit_in    = 1'b0;
                        rsp_bad_in    = 1'b1;
                     end else begin
                        state_in = ST_RMW;
                     end
                  end
                  default: begin
                     clear_all     = 1'b1;
                     rsp_strobe_in = 1'b1;
                     rsp_found_in  = 1'b0;
                     rsp_start_in  = '0;
                     rsp_bit_in    = 1'b0;
                     rsp_bad_in    = 1'b0;
                  end
               endcase
            end
         end
         ST_RMW: begin
            rsp_strobe_in = 1'b1;
            rsp_found_in  = 1'b0;
            rsp_start_in  = '0;
            rsp_bad_in    = 1'b0;
            if (kind_ff == KIND_SET) begin
               wr_en      = 1'b1;
               rsp_bit_in = 1'b0;
            end else begin
               rsp_bit_in = rd_data[idx_ff[2:0]];
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // one read issued per cycle, data of the previous address arrives
            addr_in   = addr_ff + ADDR_W'(1);
            pend_in   = 1'b1;
            scan_step = pend_ff;
            if (pend_ff && (scan_res.hit || last_byte)) begin
               rsp_strobe_in = 1'b1;
               rsp_found_in  = scan_res.hit;
               rsp_start_in  = scan_res.hit ? scan_res.start : '0;
               rsp_bit_in    = 1'b0;
               rsp_bad_in    = 1'b0;
               pend_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bytes_ff      <= CFG_W'(MAP_BYTES);
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            bytes_ff <= csr_bytes_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         idx_ff  <= req_bit_index;
         val_ff  <= req_set_value;
         want_ff <= req_run_length;
      end
      addr_ff      <= addr_in;
      data_byte_ff <= addr_ff;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_start_index = rsp_start_ff;
   assign rsp_bit_value   = rsp_bit_ff;
   assign rsp_bad_index   = rsp_bad_ff;

   a_found_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_found && rsp_bad_index))
      else $error("found and bad index reported together");

   a_miss_zero_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> (rsp_start_index == '0))
      else $error("start index nonzero on a miss");

   a_scan_kind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (kind_ff == KIND_SCAN))
      else $error("scan state entered for a non-scan item");

   a_zero_run: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_SCAN && req_run_length == '0)
      |=> (rsp_strobe && !rsp_found))
      else $error("zero run scan did not answer at once with a miss");

   a_rmw_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RMW) |=> (rsp_strobe && state_ff == ST_IDLE))
      else $error("set or test did not answer after its read");

endmodule
`default_nettype wire

// ===== hw/rtl/bra_map_mem.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bra_map_mem
// Bitmap byte store with one write and one registered read port; a valid
// bit per byte gives the all-free reset and clears the whole map at once.
// ---------------------------------------------------------------------------
module bra_map_mem
   import bra_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear_all,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0]    mem [MAP_BYTES];
   logic [MAP_BYTES-1:0] valid_ff;
   logic [BYTE_W-1:0]    rd_mem_ff;
   logic                 rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_mem_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   // a byte never written since the last clear reads as all free
   assign rd_data = rd_vld_ff ? rd_mem_ff : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/bra_run_scan.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bra_run_scan
// Free-run tracker: takes one bitmap byte per step, LSB first, and flags
// the first bit at which the run of free bits reaches the wanted length.
// ---------------------------------------------------------------------------
module bra_run_scan
   import bra_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] map_byte,
   input  wire logic [ADDR_W-1:0] byte_base,
   input  wire logic [RUN_W-1:0]  want,
   output scan_res_type           result
);

   logic [RUN_W-1:0] run_ff;
   logic [RUN_W-1:0] run_in;
   logic [RUN_W-1:0] run_v;
   logic             hit_v;
   logic [2:0]       hit_pos;
   logic [LIM_W-1:0] end_bit;
   logic [LIM_W-1:0] start_full;

   always_comb begin
      run_v   = run_ff;
      hit_v   = 1'b0;
      hit_pos = '0;
      for (int j = 0; j < BYTE_W; j++) begin
         if (!hit_v) begin
            if (map_byte[j]) begin
               run_v = '0;
            end else begin
               run_v = run_v + RUN_W'(1);
               if (run_v == want) begin
                  hit_v   = 1'b1;
                  hit_pos = 3'(j);
               end
            end
         end
      end
   end

   // start = bit + 1 - want, bit being the position where the run completes
   assign end_bit       = {1'b0, byte_base, hit_pos} + LIM_W'(1);
   assign start_full    = end_bit - want;
   assign result.hit    = step && hit_v;
   assign result.start  = start_full[IDX_W-1:0];

   always_comb begin
      run_in = run_ff;
      if (clear) begin
         run_in = '0;
      end else if (step) begin
         run_in = run_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

endmodule
`default_nettype wire

// ===== sim/bitmap_run_allocator_top_tb.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_run_allocator_top_tb
// Self-checking bench for the first-fit bitmap run allocator. A planned list
// of items and bytes_in_use writes drives the block. Scans, bit writes, bit
// reads and clears are predicted against a local copy of the bitmap, and
// every strobed result is checked in order against the predictions.
// ---------------------------------------------------------------------------
module bitmap_run_allocator_top_tb
   import bra_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned TAIL_CYCLES = 140;
   localparam int unsigned CSR_SETTLE  = 3;
   localparam int unsigned IDLE_PCT    = 17;

   typedef enum logic [1:0] {ACT_ITEM, ACT_CSR, ACT_DRAIN} plan_act_type;

   typedef struct {
      plan_act_type     act;
      bit               no_gap;
      logic [1:0]       kind;
      logic [IDX_W-1:0] idx;
      logic             val;
      logic [RUN_W-1:0] want;
      logic [CFG_W-1:0] bytes;
   } plan_entry_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] start_index;
      logic             bit_value;
      logic             bad_index;
   } alloc_rsp_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [1:0]       req_kind = KIND_SCAN;
   logic [IDX_W-1:0] req_bit_index = '0;
   logic             req_set_value = 1'b0;
   logic [RUN_W-1:0] req_run_length = '0;
   logic             rsp_strobe;
   logic             rsp_found;
   logic [IDX_W-1:0] rsp_start_index;
   logic             rsp_bit_value;
   logic             rsp_bad_index;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_bytes_in_use = '0;

   bitmap_run_allocator_top DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_bit_index    (req_bit_index),
      .req_set_value    (req_set_value),
      .req_run_length   (req_run_length),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_start_index  (rsp_start_index),
      .rsp_bit_value    (rsp_bit_value),
      .rsp_bad_index    (rsp_bad_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bytes_in_use (csr_bytes_in_use)
   );

   plan_entry_type   req_plan_q[$];
   alloc_rsp_type    pending_rsp_q[$];
   logic [BYTE_W-1:0] shadow_map [MAP_BYTES];
   logic [CFG_W-1:0] shadow_bytes = 8'd128;
   bit               item_out = 1'b0;
   bit               csr_out = 1'b0;
   bit               gap_free = 1'b0;
   int unsigned      fail_cnt = 0;
   int unsigned      cycle_cnt = 0;
   int unsigned      settle_cnt = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // bits of the map actually managed under the current bytes_in_use
   function automatic int unsigned managed_bits();
      int unsigned n;
      n = shadow_bytes;
      if (n > MAP_BYTES) n = MAP_BYTES;
      return n * BYTE_W;
   endfunction

   function automatic alloc_rsp_type alloc_outcome(logic [1:0] kind, logic [IDX_W-1:0] idx,
                                                   logic val, logic [RUN_W-1:0] want);
      alloc_rsp_type r;
      int unsigned   lim;
      int unsigned   run;
      bit            done;
      r = '0;
      lim = managed_bits();
      run = 0;
      done = 1'b0;
      case (kind)
         KIND_SCAN: begin
            if (want != 0 && want <= lim) begin
               for (int unsigned i = 0; i < lim && !done; i++) begin
                  if (shadow_map[i / BYTE_W][i % BYTE_W]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == want) begin
                        r.found = 1'b1;
                        r.start_index = IDX_W'(i + 1 - want);
                        done = 1'b1;
                     end
                  end
               end
            end
         end
         KIND_SET, KIND_TEST: begin
            if (idx >= lim) begin
               r.bad_index = 1'b1;
            end else if (kind == KIND_SET) begin
               shadow_map[idx / BYTE_W][idx % BYTE_W] = val;
            end else begin
               r.bit_value = shadow_map[idx / BYTE_W][idx % BYTE_W];
            end
         end
         default: begin
            for (int b = 0; b < MAP_BYTES; b++) shadow_map[b] = '0;
         end
      endcase
      return r;
   endfunction

   function automatic plan_entry_type blank_entry(plan_act_type act);
      plan_entry_type e;
      e.act = act;
      e.no_gap = gap_free;
      e.kind = KIND_SCAN;
      e.idx = '0;
      e.val = 1'b0;
      e.want = '0;
      e.bytes = '0;
      return e;
   endfunction

   task automatic plan_item(logic [1:0] kind, int unsigned idx, bit val, int unsigned want);
      plan_entry_type e;
      e = blank_entry(ACT_ITEM);
      e.kind = kind;
      e.idx = IDX_W'(idx);
      e.val = val;
      e.want = RUN_W'(want);
      req_plan_q.push_back(e);
   endtask

   task automatic plan_csr(int unsigned bytes);
      plan_entry_type e;
      e = blank_entry(ACT_CSR);
      e.bytes = CFG_W'(bytes);
      req_plan_q.push_back(e);
   endtask

   // random item shaped by the managed size; fields unused by the kind stay random
   task automatic plan_random(int unsigned cfg_bytes);
      plan_entry_type e;
      int unsigned lim, span, sel, pick;
      e = blank_entry(ACT_ITEM);
      lim = (cfg_bytes > MAP_BYTES ? MAP_BYTES : cfg_bytes) * BYTE_W;
      span = (lim > 64) ? 64 : lim;
      e.idx = IDX_W'($urandom_range(1023));
      e.val = $urandom_range(1);
      e.want = RUN_W'($urandom_range(2047));
      sel = $urandom_range(99);
      if (sel < 40) e.kind = KIND_SET;
      else if (sel < 62) e.kind = KIND_TEST;
      else if (sel < 95) e.kind = KIND_SCAN;
      else e.kind = KIND_CLEAR;
      if (e.kind == KIND_SET) e.val = ($urandom_range(9) < 6);
      if (e.kind == KIND_SET || e.kind == KIND_TEST) begin
         pick = $urandom_range(9);
         // mostly the low bits, so sets pile up where the scans look
         if (lim != 0 && pick < 6) e.idx = IDX_W'($urandom_range(span - 1));
         else if (lim != 0 && pick < 9) e.idx = IDX_W'($urandom_range(lim - 1));
      end else if (e.kind == KIND_SCAN) begin
         pick = $urandom_range(19);
         if (pick < 13) e.want = RUN_W'($urandom_range(span == 0 ? 1 : span, 1));
         else if (pick < 16) e.want = RUN_W'(lim > 2 ? lim - $urandom_range(2) : lim);
         else if (pick == 19) e.want = '0;
      end
      req_plan_q.push_back(e);
   endtask

   // driver: items go out on start, csr writes only once the block has gone quiet
   always @(negedge clock) begin
      logic nxt_start;
      logic nxt_cvalid;
      plan_entry_type e;
      nxt_start = 1'b0;
      nxt_cvalid = 1'b0;
      if (!reset) begin
         if (item_out) begin
            nxt_start = 1'b1;
         end else if (csr_out) begin
            nxt_cvalid = 1'b1;
         end else if (req_plan_q.size() != 0) begin
            if (req_plan_q[0].act == ACT_ITEM) begin
               settle_cnt = 0;
               if (req_plan_q[0].no_gap || $urandom_range(99) >= IDLE_PCT) begin
                  e = req_plan_q.pop_front();
                  req_kind <= e.kind;
                  req_bit_index <= e.idx;
                  req_set_value <= e.val;
                  req_run_length <= e.want;
                  item_out = 1'b1;
                  nxt_start = 1'b1;
               end
            end else if (pending_rsp_q.size() == 0 && !busy) begin
               if (settle_cnt < CSR_SETTLE) begin
                  settle_cnt++;
               end else begin
                  settle_cnt = 0;
                  e = req_plan_q.pop_front();
                  if (e.act == ACT_CSR) begin
                     csr_bytes_in_use <= e.bytes;
                     csr_out = 1'b1;
                     nxt_cvalid = 1'b1;
                  end
               end
            end else begin
               settle_cnt = 0;
            end
         end
      end
      start <= nxt_start;
      csr_valid <= nxt_cvalid;
   end

   // monitor: check strobed results, then record what was accepted this edge
   always @(posedge clock) begin
      alloc_rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_rsp_q.size() == 0) begin
               fail_cnt++;
               $error("rsp_strobe: expected no result, got one");
            end else begin
               exp_rsp = pending_rsp_q.pop_front();
               if (rsp_found !== exp_rsp.found) begin
                  fail_cnt++;
                  $error("rsp_found: expected %0d, got %0d", exp_rsp.found, rsp_found);
               end
               if (rsp_start_index !== exp_rsp.start_index) begin
                  fail_cnt++;
                  $error("rsp_start_index: expected %0d, got %0d",
                         exp_rsp.start_index, rsp_start_index);
               end
               if (rsp_bit_value !== exp_rsp.bit_value) begin
                  fail_cnt++;
                  $error("rsp_bit_value: expected %0d, got %0d",
                         exp_rsp.bit_value, rsp_bit_value);
               end
               if (rsp_bad_index !== exp_rsp.bad_index) begin
                  fail_cnt++;
                  $error("rsp_bad_index: expected %0d, got %0d",
                         exp_rsp.bad_index, rsp_bad_index);
               end
            end
         end
         if (start && !busy) begin
            pending_rsp_q.push_back(alloc_outcome(req_kind, req_bit_index,
                                                 req_set_value, req_run_length));
            item_out = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            shadow_bytes = csr_bytes_in_use;
            csr_out = 1'b0;
         end
      end
   end

   initial begin
      int unsigned phase_bytes [12];
      for (int b = 0; b < MAP_BYTES; b++) shadow_map[b] = '0;
      phase_bytes = '{8, 1, 2, 16, 128, 4, 0, 3, 255, 32, 6, 12};
      phase_bytes[10] = $urandom_range(255, 1);

      // directed: full size, empty map
      plan_item(KIND_SCAN, 0, 0, 1024);
      plan_item(KIND_SCAN, 0, 0, 0);
      plan_item(KIND_SCAN, 0, 0, 2047);
      plan_item(KIND_SCAN, 0, 0, 1025);
      plan_item(KIND_SET, 0, 1, 0);
      plan_item(KIND_SET, 1023, 1, 0);
      plan_item(KIND_TEST, 1023, 0, 0);
      plan_item(KIND_TEST, 512, 0, 0);
      plan_item(KIND_SCAN, 0, 0, 1022);
      plan_item(KIND_SCAN, 0, 0, 1023);
      plan_item(KIND_SET, 1023, 0, 0);
      plan_item(KIND_SCAN, 0, 0, 1023);
      plan_item(KIND_CLEAR, 0, 0, 0);
      plan_item(KIND_TEST, 0, 0, 0);
      // no managed bits at all
      plan_csr(0);
      plan_item(KIND_SET, 0, 1, 0);
      plan_item(KIND_TEST, 5, 0, 0);
      plan_item(KIND_SCAN, 0, 0, 1);
      // register above the store size clamps to the full map
      plan_csr(255);
      plan_item(KIND_SET, 1023, 1, 0);
      plan_item(KIND_SCAN, 0, 0, 1024);
      plan_item(KIND_CLEAR, 0, 0, 0);
      // single byte: index just past the end and runs around the edge
      plan_csr(1);
      plan_item(KIND_SET, 8, 1, 0);
      plan_item(KIND_SET, 7, 1, 0);
      plan_item(KIND_SCAN, 0, 0, 7);
      plan_item(KIND_SCAN, 0, 0, 8);

      for (int p = 0; p < 12; p++) begin
         plan_csr(phase_bytes[p]);
         gap_free = (p == 2);
         for (int n = 0; n < 45; n++) begin
            if ((p == 4 || p == 9) && n == 20) req_plan_q.push_back(blank_entry(ACT_DRAIN));
            plan_random(phase_bytes[p]);
         end
      end
      gap_free = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      do @(posedge clock);
      while (req_plan_q.size() != 0 || item_out || csr_out || pending_rsp_q.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_rsp_q.size() != 0) begin
         fail_cnt++;
         $error("rsp_strobe: expected %0d more results, got none", pending_rsp_q.size());
      end
      if (fail_cnt == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/bra_pkg.sv
hw/rtl/bra_map_mem.sv
hw/rtl/bra_run_scan.sv
hw/rtl/bitmap_run_allocator_top.sv
sim/bitmap_run_allocator_top_tb.sv
